### hdl/utf8_stream_decoder_assert.svh
// Assertion macros used by the decoder's top-level RTL file.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define UTF8SD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define UTF8SD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/utf8sd_pkg.sv
// Widths, byte class constants and types of the UTF-8 stream decoder.
package utf8sd_pkg;

    localparam int BYTE_W    = 8;
    localparam int CP_W      = 21;
    localparam int CP_TDATA_W = ((CP_W + 7) / 8) * 8;
    localparam int PART_W    = 15;
    localparam int REM_W     = 2;
    localparam int CONT_W    = 6;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CP_W-1:0]   cp_t;
    typedef logic [PART_W-1:0] part_t;
    typedef logic [REM_W-1:0]  rem_t;

    // Byte classes.
    localparam byte_t BYTE_NUL       = 8'h00;
    localparam byte_t BYTE_ASCII_MAX = 8'h7F;
    localparam byte_t BYTE_CONT_MAX  = 8'hBF;
    localparam byte_t BYTE_LEAD2_MIN = 8'hC0;
    localparam byte_t BYTE_LEAD2_MAX = 8'hDF;
    localparam byte_t BYTE_LEAD3_MIN = 8'hE0;
    localparam byte_t BYTE_LEAD3_MAX = 8'hEF;
    localparam byte_t BYTE_LEAD4_MIN = 8'hF0;
    localparam byte_t BYTE_LEAD4_MAX = 8'hF7;

    // Payload masks of the lead bytes.
    localparam byte_t MASK_LEAD2 = 8'h1F;
    localparam byte_t MASK_LEAD3 = 8'h0F;
    localparam byte_t MASK_LEAD4 = 8'h07;

    // Continuation counts still to come after each lead byte.
    localparam rem_t REM_IDLE  = 2'd0;
    localparam rem_t REM_ONE   = 2'd1;
    localparam rem_t REM_TWO   = 2'd2;
    localparam rem_t REM_THREE = 2'd3;

endpackage

### hdl/utf8_stream_decoder.sv
// Top level of the byte-serial UTF-8 stream decoder.
// One byte goes in per item and exactly one 21-bit code point comes out per item; the
// code point is 0 when no character finished on that byte. Bytes 01..7F pass through
// while idle, lead bytes C0..DF, E0..EF and F0..F7 open sequences of 1, 2 or 3
// continuations, and any byte up to BF inside a sequence counts as a continuation.
// A byte C0..FF inside a sequence aborts it and is dropped; a zero byte resets the
// decoder. No checks for overlong forms, surrogates or values above 10FFFF are made.
// Each item passes an input register and then a result register, and the block
// sustains one item per clock cycle while the result side does not stall; the update
// of the sequence state between the two registers sets that rate.
module utf8_stream_decoder
    import utf8sd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] byte_in
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [CP_TDATA_W-1:0] m_axis_tdata    // [20:0] code_point, [23:21] zero
);

    `include "utf8_stream_decoder_assert.svh"

    logic  in_valid_reg, in_valid_next;
    byte_t in_byte_reg;
    logic  out_valid_reg, out_valid_next;
    cp_t   out_cp_reg, out_cp_next;
    rem_t  rem_reg, rem_next;
    part_t part_reg, part_next;

    logic  in_accept;
    logic  step_fire;
    cp_t   cont_value;
    cp_t   byte_cp;
    logic  ascii_step;

    // Handshake: the decode step fires when a byte is held and the result slot is free or being emptied.
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign step_fire     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step_fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(CP_TDATA_W - CP_W){1'b0}}, out_cp_reg};

    // Partial value shifted up with the low six bits of a continuation byte.
    assign cont_value = {{(CP_W - PART_W - CONT_W){1'b0}}, part_reg, in_byte_reg[CONT_W-1:0]};

    // Held byte widened to a code point, and the idle ASCII case it passes through in.
    assign byte_cp    = {{(CP_W - BYTE_W){1'b0}}, in_byte_reg};
    assign ascii_step = step_fire && (rem_reg == REM_IDLE)
                        && (in_byte_reg inside {[8'h01:BYTE_ASCII_MAX]});

    // Decode step for the held byte.
    always_comb
    begin
        out_cp_next = '0;
        rem_next    = rem_reg;
        part_next   = part_reg;
        if (in_byte_reg == BYTE_NUL)
        begin
            rem_next  = REM_IDLE;
            part_next = '0;
        end
        else if (rem_reg == REM_IDLE)
        begin
            if (in_byte_reg inside {[8'h01:BYTE_ASCII_MAX]})
            begin
                out_cp_next = {{(CP_W - BYTE_W){1'b0}}, in_byte_reg};
            end
            else if (in_byte_reg inside {[BYTE_LEAD2_MIN:BYTE_LEAD2_MAX]})
            begin
                part_next = {{(PART_W - BYTE_W){1'b0}}, in_byte_reg & MASK_LEAD2};
                rem_next  = REM_ONE;
            end
            else if (in_byte_reg inside {[BYTE_LEAD3_MIN:BYTE_LEAD3_MAX]})
            begin
                part_next = {{(PART_W - BYTE_W){1'b0}}, in_byte_reg & MASK_LEAD3};
                rem_next  = REM_TWO;
            end
            else if (in_byte_reg inside {[BYTE_LEAD4_MIN:BYTE_LEAD4_MAX]})
            begin
                part_next = {{(PART_W - BYTE_W){1'b0}}, in_byte_reg & MASK_LEAD4};
                rem_next  = REM_THREE;
            end
            // Stray continuations and bytes F8..FF are ignored while idle.
        end
        else if (in_byte_reg > BYTE_CONT_MAX)
        begin
            // A lead or invalid byte inside a sequence aborts it and is dropped.
            rem_next  = REM_IDLE;
            part_next = '0;
        end
        else if (rem_reg == REM_ONE)
        begin
            out_cp_next = cont_value;
            rem_next    = REM_IDLE;
            part_next   = '0;
        end
        else
        begin
            part_next = cont_value[PART_W-1:0];
            rem_next  = rem_reg - REM_ONE;
        end
    end

    // Valid flags of the input and result registers.
    always_comb
    begin
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step_fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (step_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and sequence state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rem_reg       <= REM_IDLE;
            part_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_fire)
            begin
                rem_reg  <= rem_next;
                part_reg <= part_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (step_fire)
        begin
            out_cp_reg <= out_cp_next;
        end
    end

    // A zero byte always leaves the decoder idle.
    `UTF8SD_ASSERT_NXT(a_nul_resets, step_fire && (in_byte_reg == BYTE_NUL),
                       rem_reg == REM_IDLE, "zero byte did not reset the decoder")

    // ASCII taken while idle comes out unchanged in the next result.
    `UTF8SD_ASSERT_NXT(a_ascii_pass, ascii_step,
                       m_axis_tvalid && (out_cp_reg == $past(byte_cp)),
                       "ASCII byte not passed through")

    // An empty input register never blocks the input side.
    `UTF8SD_ASSERT_IMP(a_ready_empty, !in_valid_reg, s_axis_tready, "input stalled while empty")

endmodule

### verif/tb.sv
// Self-checking testbench for the byte-serial UTF-8 stream decoder.
`timescale 1ns / 100ps

module tb;
    import utf8sd_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    localparam int PHASE_ITEMS  = 500;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 100;
    localparam int DIRECTED_N   = 28;

    // One row of the directed table: the byte, and a typed-in code point where one is given.
    typedef struct packed {
        byte_t data;
        bit    has_cp;
        cp_t   cp;
    } stim_row_t;

    localparam stim_row_t DIRECTED [DIRECTED_N] = '{
        // ASCII extremes, zero byte, invalid and stray bytes while idle
        '{8'h01, 1'b1, 21'h000001},
        '{8'h7F, 1'b1, 21'h00007F},
        '{8'h00, 1'b1, 21'h000000},
        '{8'hFF, 1'b1, 21'h000000},
        '{8'hF8, 1'b1, 21'h000000},
        '{8'h80, 1'b1, 21'h000000},
        '{8'hBF, 1'b1, 21'h000000},
        // Two-byte sequence whose continuation has its top bit clear
        '{8'hC3, 1'b1, 21'h000000},
        '{8'h41, 1'b0, 21'h000000},
        // Three-byte and four-byte sequences
        '{8'hE2, 1'b1, 21'h000000},
        '{8'h82, 1'b1, 21'h000000},
        '{8'hAC, 1'b0, 21'h000000},
        '{8'hF0, 1'b1, 21'h000000},
        '{8'h9F, 1'b1, 21'h000000},
        '{8'h98, 1'b1, 21'h000000},
        '{8'h80, 1'b0, 21'h000000},
        // Largest value that a four-byte sequence can carry
        '{8'hF7, 1'b1, 21'h000000},
        '{8'hBF, 1'b1, 21'h000000},
        '{8'hBF, 1'b1, 21'h000000},
        '{8'hBF, 1'b1, 21'h1FFFFF},
        // Encoded zero looks the same as no character
        '{8'hC0, 1'b1, 21'h000000},
        '{8'h80, 1'b1, 21'h000000},
        // Abort by a lead byte, which is dropped and does not open a sequence
        '{8'hE0, 1'b1, 21'h000000},
        '{8'h8F, 1'b1, 21'h000000},
        '{8'hF0, 1'b1, 21'h000000},
        '{8'h01, 1'b1, 21'h000001},
        // Zero byte in the middle of a sequence
        '{8'hE1, 1'b1, 21'h000000},
        '{8'h00, 1'b1, 21'h000000}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata = '0;   // [7:0] byte_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [CP_TDATA_W-1:0] m_axis_tdata;        // [20:0] code_point, [23:21] zero

    // Decoder state as the testbench tracks it.
    rem_t  conts_needed = REM_IDLE;
    rem_t  conts_taken  = '0;
    cp_t   partial_cp   = '0;

    cp_t   expected_cps [$];
    byte_t stim_bytes [$];
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    int    error_count    = 0;
    int    quiet_cycles   = 0;

    utf8_stream_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (error_count < PRINT_LIMIT)
        begin
            $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        end
        error_count++;
    endtask

    function automatic void clear_decoder();
        conts_needed = REM_IDLE;
        conts_taken  = '0;
        partial_cp   = '0;
    endfunction

    function automatic void open_sequence(rem_t conts, byte_t payload);
        conts_needed = conts;
        conts_taken  = '0;
        partial_cp   = cp_t'(payload);
    endfunction

    // Advances the tracked state by one byte and returns the code point it finishes.
    function automatic cp_t decode_byte(byte_t b);
        cp_t cp_out;
        cp_t grown;
        cp_out = '0;
        if (b == BYTE_NUL)
        begin
            clear_decoder();
        end
        else if (conts_needed == REM_IDLE)
        begin
            // Stray continuations and F8..FF fall through and leave the decoder idle.
            if (b <= BYTE_ASCII_MAX)
                cp_out = cp_t'(b);
            else if (b >= BYTE_LEAD4_MIN && b <= BYTE_LEAD4_MAX)
                open_sequence(REM_THREE, b & MASK_LEAD4);
            else if (b >= BYTE_LEAD3_MIN && b <= BYTE_LEAD3_MAX)
                open_sequence(REM_TWO, b & MASK_LEAD3);
            else if (b >= BYTE_LEAD2_MIN && b <= BYTE_LEAD2_MAX)
                open_sequence(REM_ONE, b & MASK_LEAD2);
        end
        else if (b > BYTE_CONT_MAX)
        begin
            clear_decoder();
        end
        else
        begin
            // Any byte up to BF counts; only its low six bits are kept.
            grown = {partial_cp[CP_W-CONT_W-1:0], b[CONT_W-1:0]};
            if (int'(conts_taken) + 1 >= int'(conts_needed))
            begin
                cp_out = grown;
                clear_decoder();
            end
            else
            begin
                partial_cp  = grown;
                conts_taken = conts_taken + 1'b1;
            end
        end
        return cp_out;
    endfunction

    // Queues a lead byte and its continuations; cut_at ends it early with cut_byte,
    // plain_at puts a byte without the continuation marker in one place.
    task automatic add_sequence(int conts, int cut_at, byte_t cut_byte, int plain_at);
        byte_t lead;
        case (conts)
            1:       lead = byte_t'($urandom_range(BYTE_LEAD2_MAX, BYTE_LEAD2_MIN));
            2:       lead = byte_t'($urandom_range(BYTE_LEAD3_MAX, BYTE_LEAD3_MIN));
            default: lead = byte_t'($urandom_range(BYTE_LEAD4_MAX, BYTE_LEAD4_MIN));
        endcase
        stim_bytes.push_back(lead);
        for (int i = 0; i < conts; i++)
        begin
            if (i == cut_at)
            begin
                stim_bytes.push_back(cut_byte);
                break;
            end
            else if (i == plain_at)
                stim_bytes.push_back(byte_t'($urandom_range(BYTE_ASCII_MAX, 1)));
            else
                stim_bytes.push_back(byte_t'($urandom_range(BYTE_CONT_MAX, 8'h80)));
        end
    endtask

    // Mostly well-formed text, with broken sequences and noise mixed in.
    task automatic add_random_run();
        int pick;
        int conts;
        pick  = $urandom_range(99);
        conts = $urandom_range(3, 1);
        if (pick < 25)
        begin
            repeat ($urandom_range(4, 1))
                stim_bytes.push_back(byte_t'($urandom_range(BYTE_ASCII_MAX, 1)));
        end
        else if (pick < 75)
            add_sequence(conts, -1, BYTE_NUL, -1);
        else if (pick < 80)
            add_sequence(conts, -1, BYTE_NUL, $urandom_range(conts - 1));
        else if (pick < 87)
            add_sequence(conts, $urandom_range(conts - 1),
                         byte_t'($urandom_range(8'hFF, BYTE_LEAD2_MIN)), -1);
        else if (pick < 90)
            add_sequence(conts, $urandom_range(conts - 1), BYTE_NUL, -1);
        else if (pick < 95)
        begin
            if ($urandom_range(1) == 1)
                stim_bytes.push_back(byte_t'($urandom_range(BYTE_CONT_MAX, 8'h80)));
            else
                stim_bytes.push_back(byte_t'($urandom_range(8'hFF, BYTE_LEAD4_MAX + 1)));
        end
        else
            stim_bytes.push_back(byte_t'($urandom_range(8'hFF, 0)));
    endtask

    // Offers one item, waits for it to be taken and records the code point it should give.
    task automatic send_item(byte_t data, bit has_cp, cp_t typed_cp);
        cp_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = decode_byte(data);
        expected_cps.push_back(has_cp ? typed_cp : predicted);
    endtask

    // Result side: random stalls and comparison against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        cp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_cps.size() == 0)
                report_mismatch("result item with nothing expected", 32'(m_axis_tdata), 0);
            else
            begin
                want = expected_cps.pop_front();
                if (m_axis_tdata[CP_W-1:0] !== want)
                    report_mismatch("code_point", 32'(m_axis_tdata[CP_W-1:0]), 32'(want));
            end
            if (m_axis_tdata[CP_TDATA_W-1:CP_W] !== '0)
                report_mismatch("tdata padding", 32'(m_axis_tdata[CP_TDATA_W-1:CP_W]), 0);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles in which no item moves on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Reset, directed table, then random phases with different idle patterns.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_item(DIRECTED[i].data, DIRECTED[i].has_cp, DIRECTED[i].cp);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            stim_bytes.delete();
            while (stim_bytes.size() < PHASE_ITEMS)
                add_random_run();
            foreach (stim_bytes[i])
                send_item(stim_bytes[i], 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (expected_cps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/utf8sd_pkg.sv
hdl/utf8_stream_decoder.sv
verif/tb.sv
